// File: hw/rtl/bblc_pkg.sv
package bblc_pkg;

    localparam int KEY_W    = 48;
    localparam int GEN_W    = 32;
    localparam int PAGE_W   = 16;
    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 32;
    localparam int BYTES_W  = 40;

    localparam logic [BYTES_W-1:0] BUDGET_RESET = 40'd268435456;

    typedef enum logic [2:0] {
        ACT_INSERT    = 3'd0,
        ACT_LOOKUP    = 3'd1,
        ACT_PIN_CLEAR = 3'd2,
        ACT_PIN_ADD   = 3'd3,
        ACT_CLEAR_GEN = 3'd4,
        ACT_HOLD_ADD  = 3'd5,
        ACT_RETAIN    = 3'd6,
        ACT_ENFORCE   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_LIST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        SC_FIND,
        SC_GEN,
        SC_RETAIN,
        SC_UNPIN,
        SC_VICTIM,
        SC_FIX
    } scan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_W,
        S_INS_FIX_W,
        S_INS_WR,
        S_ENF_CHK,
        S_VIC_W,
        S_ENF_FIX_W,
        S_TOUCH_FIX_W,
        S_TOUCH,
        S_UNPIN_W,
        S_SWEEP_W,
        S_SWEEP_FIX_W,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    latch_in;
        logic    scan_go;
        scan_t   scan_kind;
        logic    scan_from_next;
        logic    drop;
        logic    ins_write;
        logic    touch_write;
        logic    pin_clear_tbl;
        logic    pin_add;
        logic    set_pin;
        logic    hold_add;
        logic    hold_clear;
        logic    peak_upd;
        logic    set_status;
        status_t status_val;
        logic    out_load;
    } bblc_cmd_t;

    typedef struct packed {
        action_t action;
        logic    busy;
        logic    found;
        logic    has_free;
        logic    over;
        logic    pin_listed;
        logic    pin_full;
        logic    hold_listed;
        logic    hold_full;
        logic    out_free;
    } bblc_stat_t;

endpackage

// File: hw/rtl/bblc_if.sv
interface bblc_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [31:0] generation;
    logic [15:0] page;
    logic [15:0] range_last;
    logic [31:0] image_bytes;
    logic [31:0] image_handle;

    modport source (output valid, action, generation, page, range_last, image_bytes,
                    image_handle, input ready);
    modport sink (input valid, action, generation, page, range_last, image_bytes,
                  image_handle, output ready);
endinterface

interface bblc_rsp_if #(parameter int CNT_W = 7);
    logic             valid;
    logic             ready;
    logic             hit;
    logic [31:0]      handle_out;
    logic [39:0]      bytes_used;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] peak_entries;
    logic             over_budget;
    logic [1:0]       status;

    modport source (output valid, hit, handle_out, bytes_used, entry_count, peak_entries,
                    over_budget, status, input ready);
    modport sink (input valid, hit, handle_out, bytes_used, entry_count, peak_entries,
                  over_budget, status, output ready);
endinterface

// File: hw/rtl/byte_budget_lru_cache_with_pins_core.sv
// channel  dir  words                                             handshake
// req      in   action, generation, page, range_last, bytes, hdl  valid/ready
// rsp      out  hit, handle_out, bytes_used, counts, over, status valid/ready
// cfg      in   budget_bytes                                      cfg_we, no wait
//
// One word at a time. Each table pass goes through the single read port of the
// entry RAM: lookup 1-2 passes, pin_add one pass or none, insert 1-2 passes
// plus two per eviction, clear_generation and retain_range one pass plus two per
// removed entry; pin_clear one pass, hold_add no pass.
// No clearing pass after reset. A held rsp word does not block taking the next
// req word; it only delays that word's result.
module byte_budget_lru_cache_with_pins_core #(
    parameter int ENTRIES    = 64,
    parameter int PIN_DEPTH  = 16,
    parameter int HOLD_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bblc_req_if.sink                   req,
    bblc_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [bblc_pkg::BYTES_W-1:0] cfg_wdata
);
    import bblc_pkg::*;

    bblc_cmd_t  cmd;
    bblc_stat_t stat;

    bblc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bblc_dp #(
        .ENTRIES    (ENTRIES),
        .PIN_DEPTH  (PIN_DEPTH),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (req.action),
        .generation   (req.generation),
        .page         (req.page),
        .range_last   (req.range_last),
        .image_bytes  (req.image_bytes),
        .image_handle (req.image_handle),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .hit          (rsp.hit),
        .handle_out   (rsp.handle_out),
        .bytes_used   (rsp.bytes_used),
        .entry_count  (rsp.entry_count),
        .peak_entries (rsp.peak_entries),
        .over_budget  (rsp.over_budget),
        .status       (rsp.status),
        .cmd          (cmd),
        .stat         (stat)
    );
endmodule

// File: hw/rtl/bblc_ram.sv
module bblc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/bblc_ctrl.sv
module bblc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bblc_pkg::bblc_stat_t   stat,
    output bblc_pkg::bblc_cmd_t    cmd
);
    import bblc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_INSERT, ACT_LOOKUP: state_next = S_FIND_W;
                    ACT_PIN_CLEAR:          state_next = S_UNPIN_W;
                    ACT_PIN_ADD:
                        state_next = (!stat.pin_listed && stat.pin_full) ? S_DONE : S_FIND_W;
                    ACT_CLEAR_GEN, ACT_RETAIN: state_next = S_SWEEP_W;
                    ACT_HOLD_ADD:           state_next = S_DONE;
                    ACT_ENFORCE:            state_next = S_ENF_CHK;
                    default:                state_next = S_DONE;
                endcase
            end
            S_FIND_W:
            begin
                if (!stat.busy)
                begin
                    if (stat.action == ACT_INSERT)
                        state_next = stat.found ? S_INS_FIX_W : S_INS_WR;
                    else if (stat.action == ACT_LOOKUP && stat.found)
                        state_next = S_TOUCH_FIX_W;
                    else
                        state_next = S_DONE;
                end
            end
            S_INS_FIX_W:
            begin
                if (!stat.busy)
                    state_next = S_INS_WR;
            end
            S_INS_WR:      state_next = stat.has_free ? S_ENF_CHK : S_DONE;
            S_ENF_CHK:     state_next = stat.over ? S_VIC_W : S_DONE;
            S_VIC_W:
            begin
                if (!stat.busy)
                    state_next = stat.found ? S_ENF_FIX_W : S_DONE;
            end
            S_ENF_FIX_W:
            begin
                if (!stat.busy)
                    state_next = S_ENF_CHK;
            end
            S_TOUCH_FIX_W:
            begin
                if (!stat.busy)
                    state_next = S_TOUCH;
            end
            S_TOUCH:       state_next = S_DONE;
            S_UNPIN_W:
            begin
                if (!stat.busy)
                    state_next = S_DONE;
            end
            S_SWEEP_W:
            begin
                if (!stat.busy)
                    state_next = stat.found ? S_SWEEP_FIX_W : S_DONE;
            end
            S_SWEEP_FIX_W:
            begin
                if (!stat.busy)
                    state_next = S_SWEEP_W;
            end
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.scan_kind = SC_FIND;
        cmd.status_val = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = in_valid;
            end
            S_DISPATCH:
            begin
                unique case (stat.action)
                    ACT_INSERT, ACT_LOOKUP:
                    begin
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_FIND;
                    end
                    ACT_PIN_CLEAR:
                    begin
                        cmd.pin_clear_tbl = 1'b1;
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_UNPIN;
                    end
                    ACT_PIN_ADD:
                    begin
                        if (!stat.pin_listed && stat.pin_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_LIST_FULL;
                        end
                        else
                        begin
                            cmd.pin_add = 1'b1;
                            cmd.scan_go = 1'b1;
                            cmd.scan_kind = SC_FIND;
                        end
                    end
                    ACT_CLEAR_GEN:
                    begin
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_GEN;
                    end
                    ACT_RETAIN:
                    begin
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_RETAIN;
                    end
                    ACT_HOLD_ADD:
                    begin
                        if (!stat.hold_listed && stat.hold_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_LIST_FULL;
                        end
                        else
                        begin
                            cmd.hold_add = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_FIND_W:
            begin
                if (!stat.busy && stat.found)
                begin
                    if (stat.action == ACT_INSERT)
                    begin
                        cmd.drop = 1'b1;
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_FIX;
                    end
                    else if (stat.action == ACT_LOOKUP)
                    begin
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_FIX;
                    end
                    else
                    begin
                        cmd.set_pin = 1'b1;
                    end
                end
            end
            S_INS_WR:
            begin
                if (stat.has_free)
                begin
                    cmd.ins_write = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_TABLE_FULL;
                end
            end
            S_ENF_CHK:
            begin
                if (stat.over)
                begin
                    cmd.scan_go = 1'b1;
                    cmd.scan_kind = SC_VICTIM;
                end
                else
                begin
                    cmd.peak_upd = (stat.action == ACT_INSERT);
                end
            end
            S_VIC_W:
            begin
                if (!stat.busy)
                begin
                    if (stat.found)
                    begin
                        cmd.drop = 1'b1;
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_FIX;
                    end
                    else
                    begin
                        cmd.peak_upd = (stat.action == ACT_INSERT);
                    end
                end
            end
            S_TOUCH:
            begin
                cmd.touch_write = 1'b1;
            end
            S_SWEEP_W:
            begin
                if (!stat.busy)
                begin
                    if (stat.found)
                    begin
                        cmd.drop = 1'b1;
                        cmd.scan_go = 1'b1;
                        cmd.scan_kind = SC_FIX;
                    end
                    else if (stat.action == ACT_CLEAR_GEN)
                    begin
                        cmd.pin_clear_tbl = 1'b1;
                    end
                    else
                    begin
                        cmd.hold_clear = 1'b1;
                    end
                end
            end
            S_SWEEP_FIX_W:
            begin
                if (!stat.busy)
                begin
                    cmd.scan_go = 1'b1;
                    cmd.scan_from_next = 1'b1;
                    cmd.scan_kind = (stat.action == ACT_CLEAR_GEN) ? SC_GEN : SC_RETAIN;
                end
            end
            S_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default: ;
        endcase
    end
endmodule

// File: hw/rtl/bblc_dp.sv
module bblc_dp #(
    parameter int ENTRIES    = 64,
    parameter int PIN_DEPTH  = 16,
    parameter int HOLD_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [2:0]                            action,
    input  logic [bblc_pkg::GEN_W-1:0]            generation,
    input  logic [bblc_pkg::PAGE_W-1:0]           page,
    input  logic [bblc_pkg::PAGE_W-1:0]           range_last,
    input  logic [bblc_pkg::SIZE_W-1:0]           image_bytes,
    input  logic [bblc_pkg::HANDLE_W-1:0]         image_handle,
    input  logic                                  cfg_we,
    input  logic [bblc_pkg::BYTES_W-1:0]          cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic [bblc_pkg::HANDLE_W-1:0]         handle_out,
    output logic [bblc_pkg::BYTES_W-1:0]          bytes_used,
    output logic [$clog2(ENTRIES+1)-1:0]          entry_count,
    output logic [$clog2(ENTRIES+1)-1:0]          peak_entries,
    output logic                                  over_budget,
    output logic [1:0]                            status,
    input  bblc_pkg::bblc_cmd_t                   cmd,
    output bblc_pkg::bblc_stat_t                  stat
);
    import bblc_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int W  = KEY_W + SIZE_W + HANDLE_W + IW;
    localparam int HO = IW;
    localparam int SO = IW + HANDLE_W;
    localparam int KO = IW + HANDLE_W + SIZE_W;
    localparam logic [IW:0] LAST_SLOT = (IW+1)'(ENTRIES - 1);
    localparam logic [IW:0] NUM_SLOTS = (IW+1)'(ENTRIES);

    action_t                act_reg;
    logic [GEN_W-1:0]       gen_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [PAGE_W-1:0]      last_reg;
    logic [SIZE_W-1:0]      bytes_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    status_t                status_reg;
    logic [BYTES_W-1:0]     budget_reg;

    logic [ENTRIES-1:0]     valid_reg;
    logic [ENTRIES-1:0]     pinned_reg;
    logic [BYTES_W-1:0]     used_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          peak_reg;

    logic [PIN_DEPTH-1:0]   pin_v_reg;
    logic [KEY_W-1:0]       pin_key_reg [PIN_DEPTH];
    logic [HOLD_DEPTH-1:0]  hold_v_reg;
    logic [PAGE_W-1:0]      hold_page_reg [HOLD_DEPTH];

    logic                   scan_on_reg;
    logic [IW:0]            scan_cnt_reg;
    scan_t                  kind_reg;
    logic                   p_vld_reg;
    logic [IW-1:0]          p_idx_reg;
    logic                   found_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [W-1:0]           hit_word_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic [IW-1:0]          fix_r_reg;

    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [HANDLE_W-1:0]    handle_out_reg;
    logic [BYTES_W-1:0]     bytes_out_reg;
    logic [CW-1:0]          count_out_reg;
    logic [CW-1:0]          peak_out_reg;
    logic                   over_out_reg;
    logic [1:0]             status_out_reg;

    logic [KEY_W-1:0]       key;
    logic [W-1:0]           rd_data;
    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [W-1:0]           ram_wdata;

    logic                   e_vld;
    logic                   e_pin;
    logic [KEY_W-1:0]       e_key;
    logic [PAGE_W-1:0]      e_page;
    logic [IW-1:0]          e_rank;
    logic                   e_gen_hit;
    logic                   e_in_range;
    logic                   e_held;
    logic                   e_sel;
    logic                   e_take;
    logic                   e_fix;

    logic                   pin_listed;
    logic                   pin_full;
    logic [PIN_DEPTH-1:0]   pin_free_oh;
    logic                   hold_listed;
    logic                   hold_full;
    logic [HOLD_DEPTH-1:0]  hold_free_oh;
    logic                   pin_seen;
    logic                   hold_seen;

    logic [IW:0]            scan_start;
    logic [IW-1:0]          ins_slot;
    logic                   over;
    logic                   out_free;

    assign key = {gen_reg, page_reg};
    assign over = used_reg > budget_reg;
    assign out_free = !out_valid_reg || out_ready;

    bblc_ram #(
        .WIDTH (W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IW-1:0]),
        .rdata (rd_data)
    );

    // pin table and hold list lookups
    always_comb
    begin
        pin_listed = 1'b0;
        pin_seen = 1'b0;
        pin_free_oh = '0;
        for (int i = 0; i < PIN_DEPTH; i++)
        begin
            if (pin_v_reg[i] && pin_key_reg[i] == key)
                pin_listed = 1'b1;
            if (!pin_v_reg[i] && !pin_seen)
            begin
                pin_free_oh[i] = 1'b1;
                pin_seen = 1'b1;
            end
        end
        pin_full = &pin_v_reg;
    end

    always_comb
    begin
        hold_listed = 1'b0;
        hold_seen = 1'b0;
        hold_free_oh = '0;
        e_held = 1'b0;
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (hold_v_reg[i] && hold_page_reg[i] == page_reg)
                hold_listed = 1'b1;
            if (hold_v_reg[i] && hold_page_reg[i] == e_page)
                e_held = 1'b1;
            if (!hold_v_reg[i] && !hold_seen)
            begin
                hold_free_oh[i] = 1'b1;
                hold_seen = 1'b1;
            end
        end
        hold_full = &hold_v_reg;
    end

    // slot evaluation on the word read back from the table
    always_comb
    begin
        e_vld = valid_reg[p_idx_reg];
        e_pin = pinned_reg[p_idx_reg];
        e_key = rd_data[KO +: KEY_W];
        e_page = e_key[PAGE_W-1:0];
        e_rank = rd_data[IW-1:0];
        e_gen_hit = e_vld && (e_key[KEY_W-1:PAGE_W] == gen_reg);
        e_in_range = (e_page >= page_reg) && (e_page <= last_reg);
        case (kind_reg)
            SC_FIND:   e_sel = e_vld && (e_key == key);
            SC_GEN:    e_sel = e_gen_hit;
            SC_RETAIN: e_sel = e_gen_hit && !e_in_range && !e_pin && !e_held;
            SC_VICTIM: e_sel = e_vld && !e_pin;
            default:   e_sel = 1'b0;
        endcase
        if (kind_reg == SC_VICTIM)
            e_take = p_vld_reg && e_sel && (!found_reg || e_rank < hit_word_reg[IW-1:0]);
        else
            e_take = p_vld_reg && e_sel && !found_reg;
        e_fix = p_vld_reg && (kind_reg == SC_FIX) && e_vld && (e_rank > fix_r_reg);
    end

    assign scan_start = cmd.scan_from_next ? ({1'b0, hit_idx_reg} + 1'b1) : '0;
    assign ins_slot = (found_reg && !(free_found_reg && free_idx_reg < hit_idx_reg))
                      ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = p_idx_reg;
        ram_wdata = {rd_data[W-1:IW], e_rank - 1'b1};
        if (e_fix)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.ins_write)
        begin
            ram_we = 1'b1;
            ram_waddr = ins_slot;
            ram_wdata = {key, bytes_reg, handle_reg, count_reg[IW-1:0]};
        end
        else if (cmd.touch_write)
        begin
            ram_we = 1'b1;
            ram_waddr = hit_idx_reg;
            ram_wdata = {hit_word_reg[W-1:IW], IW'(count_reg - 1'b1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            valid_reg <= '0;
            pinned_reg <= '0;
            used_reg <= '0;
            count_reg <= '0;
            peak_reg <= '0;
            pin_v_reg <= '0;
            hold_v_reg <= '0;
            scan_on_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                budget_reg <= cfg_wdata;

            p_vld_reg <= scan_on_reg;
            if (cmd.scan_go)
                scan_on_reg <= scan_start < NUM_SLOTS;
            else if (scan_on_reg && scan_cnt_reg == LAST_SLOT)
                scan_on_reg <= 1'b0;

            if (p_vld_reg && kind_reg == SC_UNPIN && e_gen_hit)
                pinned_reg[p_idx_reg] <= 1'b0;
            if (cmd.drop)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
                pinned_reg[hit_idx_reg] <= 1'b0;
                used_reg <= used_reg - BYTES_W'(hit_word_reg[SO +: SIZE_W]);
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.ins_write)
            begin
                valid_reg[ins_slot] <= 1'b1;
                pinned_reg[ins_slot] <= pin_listed;
                used_reg <= used_reg + BYTES_W'(bytes_reg);
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.set_pin)
                pinned_reg[hit_idx_reg] <= 1'b1;
            if (cmd.peak_upd && count_reg > peak_reg)
                peak_reg <= count_reg;

            for (int i = 0; i < PIN_DEPTH; i++)
            begin
                if (cmd.pin_clear_tbl && pin_key_reg[i][KEY_W-1:PAGE_W] == gen_reg)
                    pin_v_reg[i] <= 1'b0;
                if (cmd.pin_add && !pin_listed && pin_free_oh[i])
                    pin_v_reg[i] <= 1'b1;
            end
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (cmd.hold_clear)
                    hold_v_reg[i] <= 1'b0;
                if (cmd.hold_add && !hold_listed && hold_free_oh[i])
                    hold_v_reg[i] <= 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg <= action_t'(action);
            gen_reg <= generation;
            page_reg <= page;
            last_reg <= range_last;
            bytes_reg <= image_bytes;
            handle_reg <= image_handle;
            status_reg <= ST_OK;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status_val;
        end

        for (int i = 0; i < PIN_DEPTH; i++)
        begin
            if (cmd.pin_add && !pin_listed && pin_free_oh[i])
                pin_key_reg[i] <= key;
        end
        for (int i = 0; i < HOLD_DEPTH; i++)
        begin
            if (cmd.hold_add && !hold_listed && hold_free_oh[i])
                hold_page_reg[i] <= page_reg;
        end

        p_idx_reg <= scan_cnt_reg[IW-1:0];
        if (cmd.scan_go)
        begin
            scan_cnt_reg <= scan_start;
            kind_reg <= cmd.scan_kind;
            if (cmd.scan_kind == SC_FIX)
            begin
                fix_r_reg <= hit_word_reg[IW-1:0];
            end
            else
            begin
                found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
        end
        else
        begin
            if (scan_on_reg)
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (e_take)
            begin
                found_reg <= 1'b1;
                hit_idx_reg <= p_idx_reg;
                hit_word_reg <= rd_data;
            end
            if (p_vld_reg && kind_reg == SC_FIND && !e_vld && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg <= p_idx_reg;
            end
        end

        if (cmd.out_load)
        begin
            hit_reg <= (act_reg == ACT_LOOKUP) && found_reg;
            handle_out_reg <= ((act_reg == ACT_LOOKUP) && found_reg)
                              ? hit_word_reg[HO +: HANDLE_W] : '0;
            bytes_out_reg <= used_reg;
            count_out_reg <= count_reg;
            peak_out_reg <= peak_reg;
            over_out_reg <= over;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign handle_out = handle_out_reg;
    assign bytes_used = bytes_out_reg;
    assign entry_count = count_out_reg;
    assign peak_entries = peak_out_reg;
    assign over_budget = over_out_reg;
    assign status = status_out_reg;

    always_comb
    begin
        stat.action = act_reg;
        stat.busy = scan_on_reg || p_vld_reg;
        stat.found = found_reg;
        stat.has_free = free_found_reg || found_reg;
        stat.over = over;
        stat.pin_listed = pin_listed;
        stat.pin_full = pin_full;
        stat.hold_listed = hold_listed;
        stat.hold_full = hold_full;
        stat.out_free = out_free;
    end
endmodule

// File: hw/rtl/bblc_chk.sv
module bblc_chk #(
    parameter int CNT_W = 7
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             hit,
    input logic [31:0]      handle_out,
    input logic [39:0]      bytes_used,
    input logic [CNT_W-1:0] entry_count,
    input logic [CNT_W-1:0] peak_entries
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while a word is in work");

    a_miss_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> handle_out == 32'd0)
        else $error("handle on a miss");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= peak_entries)
        else $error("entry count above peak");

    a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_count == '0 |-> bytes_used == 40'd0)
        else $error("bytes left in an empty table");
endmodule

bind byte_budget_lru_cache_with_pins_core bblc_chk #(
    .CNT_W ($clog2(ENTRIES + 1))
) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .hit          (rsp.hit),
    .handle_out   (rsp.handle_out),
    .bytes_used   (rsp.bytes_used),
    .entry_count  (rsp.entry_count),
    .peak_entries (rsp.peak_entries)
);

// File: tb/tb_byte_budget_lru_cache_with_pins_core.sv
`timescale 1ns / 100ps

module tb_byte_budget_lru_cache_with_pins_core;
    import bblc_pkg::*;

    localparam int SLOTS     = 64;
    localparam int PIN_SLOTS = 16;
    localparam int HOLD_SLOTS = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        action_t     action;
        logic [31:0] generation;
        logic [15:0] page;
        logic [15:0] range_last;
        logic [31:0] image_bytes;
        logic [31:0] image_handle;
    } req_word_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] handle_out;
        logic [39:0] bytes_used;
        logic [6:0]  entry_count;
        logic [6:0]  peak_entries;
        logic        over_budget;
        status_t     status;
    } rsp_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [39:0] cfg_wdata;

    bblc_req_if req_ch ();
    bblc_rsp_if #(.CNT_W(7)) rsp_ch ();

    byte_budget_lru_cache_with_pins_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // cache shadow
    logic [47:0] c_key [SLOTS];
    logic [31:0] c_size [SLOTS];
    logic [31:0] c_handle [SLOTS];
    bit          c_valid [SLOTS];
    bit          c_pinned [SLOTS];
    int unsigned c_rank [SLOTS];
    logic [47:0] pin_key [PIN_SLOTS];
    bit          pin_ok [PIN_SLOTS];
    logic [15:0] hold_page [HOLD_SLOTS];
    bit          hold_ok [HOLD_SLOTS];
    logic [39:0] used;
    int unsigned resident;
    int unsigned peak;
    logic [39:0] budget;

    req_word_t pending_words[$];
    rsp_word_t expected_rsp[$];
    int errors;
    int sent_words;
    longint cycles;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void queue_word(input req_word_t w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void queue_expect(input rsp_word_t r);
        expected_rsp = {expected_rsp, r};
    endfunction

    function automatic int find_slot(input logic [47:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (c_valid[i] && c_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void drop_slot(input int s);
        int unsigned r;
        r = c_rank[s];
        used = used - c_size[s];
        c_valid[s] = 0;
        c_pinned[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (c_valid[i] && c_rank[i] > r)
                c_rank[i]--;
        resident--;
    endfunction

    function automatic bit is_pinned_key(input logic [47:0] k);
        for (int i = 0; i < PIN_SLOTS; i++)
            if (pin_ok[i] && pin_key[i] == k)
                return 1;
        return 0;
    endfunction

    function automatic bit is_held(input logic [15:0] p);
        for (int i = 0; i < HOLD_SLOTS; i++)
            if (hold_ok[i] && hold_page[i] == p)
                return 1;
        return 0;
    endfunction

    function automatic void evict_to_budget();
        int v;
        while (used > budget)
        begin
            v = -1;
            for (int i = 0; i < SLOTS; i++)
                if (c_valid[i] && !c_pinned[i] && (v < 0 || c_rank[i] < c_rank[v]))
                    v = i;
            if (v < 0)
                break;
            drop_slot(v);
        end
    endfunction

    function automatic rsp_word_t cache_step(input req_word_t w);
        rsp_word_t o;
        logic [47:0] k;
        int s;
        int f;
        int unsigned r;
        k = {w.generation, w.page};
        o = '0;
        o.status = ST_OK;
        case (w.action)
            ACT_INSERT:
            begin
                s = find_slot(k);
                if (s >= 0)
                    drop_slot(s);
                s = 0;
                while (s < SLOTS && c_valid[s])
                    s++;
                if (s >= SLOTS)
                    o.status = ST_TABLE_FULL;
                else
                begin
                    c_key[s] = k;
                    c_size[s] = w.image_bytes;
                    c_handle[s] = w.image_handle;
                    c_valid[s] = 1;
                    c_pinned[s] = is_pinned_key(k);
                    c_rank[s] = resident;
                    resident++;
                    used = used + w.image_bytes;
                    evict_to_budget();
                    if (resident > peak)
                        peak = resident;
                end
            end
            ACT_LOOKUP:
            begin
                s = find_slot(k);
                if (s >= 0)
                begin
                    r = c_rank[s];
                    for (int i = 0; i < SLOTS; i++)
                        if (c_valid[i] && c_rank[i] > r)
                            c_rank[i]--;
                    c_rank[s] = resident - 1;
                    o.hit = 1;
                    o.handle_out = c_handle[s];
                end
            end
            ACT_PIN_CLEAR:
            begin
                for (int i = 0; i < PIN_SLOTS; i++)
                    if (pin_ok[i] && pin_key[i][47:16] == w.generation)
                        pin_ok[i] = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (c_valid[i] && c_key[i][47:16] == w.generation)
                        c_pinned[i] = 0;
            end
            ACT_PIN_ADD:
            begin
                f = 0;
                if (!is_pinned_key(k))
                begin
                    f = -1;
                    for (int i = 0; i < PIN_SLOTS && f < 0; i++)
                        if (!pin_ok[i])
                            f = i;
                    if (f >= 0)
                    begin
                        pin_ok[f] = 1;
                        pin_key[f] = k;
                    end
                end
                if (f < 0)
                    o.status = ST_LIST_FULL;
                else
                begin
                    s = find_slot(k);
                    if (s >= 0)
                        c_pinned[s] = 1;
                end
            end
            ACT_CLEAR_GEN:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (c_valid[i] && c_key[i][47:16] == w.generation)
                        drop_slot(i);
                for (int i = 0; i < PIN_SLOTS; i++)
                    if (pin_ok[i] && pin_key[i][47:16] == w.generation)
                        pin_ok[i] = 0;
            end
            ACT_HOLD_ADD:
            begin
                if (!is_held(w.page))
                begin
                    f = -1;
                    for (int i = 0; i < HOLD_SLOTS && f < 0; i++)
                        if (!hold_ok[i])
                            f = i;
                    if (f < 0)
                        o.status = ST_LIST_FULL;
                    else
                    begin
                        hold_ok[f] = 1;
                        hold_page[f] = w.page;
                    end
                end
            end
            ACT_RETAIN:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!c_valid[i] || c_key[i][47:16] != w.generation)
                        continue;
                    if (c_key[i][15:0] >= w.page && c_key[i][15:0] <= w.range_last)
                        continue;
                    if (c_pinned[i] || is_held(c_key[i][15:0]))
                        continue;
                    drop_slot(i);
                end
                for (int i = 0; i < HOLD_SLOTS; i++)
                    hold_ok[i] = 0;
            end
            default:
                evict_to_budget();
        endcase
        o.bytes_used = used;
        o.entry_count = resident[6:0];
        o.peak_entries = peak[6:0];
        o.over_budget = used > budget;
        return o;
    endfunction

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // request driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                queue_expect(cache_step(pending_words.pop_front()));
                sent_words++;
                send_gap = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                    send_gap = 0;
            end
            if (req_ch.valid && !req_ch.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                req_ch.valid <= 1'b1;
                req_ch.action <= pending_words[0].action;
                req_ch.generation <= pending_words[0].generation;
                req_ch.page <= pending_words[0].page;
                req_ch.range_last <= pending_words[0].range_last;
                req_ch.image_bytes <= pending_words[0].image_bytes;
                req_ch.image_handle <= pending_words[0].image_handle;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // response monitor
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t got;
        rsp_word_t exp_w;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = '{rsp_ch.hit, rsp_ch.handle_out, rsp_ch.bytes_used,
                        rsp_ch.entry_count, rsp_ch.peak_entries, rsp_ch.over_budget,
                        status_t'(rsp_ch.status)};
                if (expected_rsp.size() == 0)
                    report("result word with nothing expected");
                else
                begin
                    exp_w = expected_rsp.pop_front();
                    if (got.hit !== exp_w.hit)
                        report($sformatf("hit %0b exp %0b", got.hit, exp_w.hit));
                    if (got.handle_out !== exp_w.handle_out)
                        report($sformatf("handle_out %h exp %h", got.handle_out,
                                         exp_w.handle_out));
                    if (got.bytes_used !== exp_w.bytes_used)
                        report($sformatf("bytes_used %h exp %h", got.bytes_used,
                                         exp_w.bytes_used));
                    if (got.entry_count !== exp_w.entry_count)
                        report($sformatf("entry_count %0d exp %0d", got.entry_count,
                                         exp_w.entry_count));
                    if (got.peak_entries !== exp_w.peak_entries)
                        report($sformatf("peak_entries %0d exp %0d", got.peak_entries,
                                         exp_w.peak_entries));
                    if (got.over_budget !== exp_w.over_budget)
                        report($sformatf("over_budget %0b exp %0b", got.over_budget,
                                         exp_w.over_budget));
                    if (got.status !== exp_w.status)
                        report($sformatf("status %0d exp %0d", got.status, exp_w.status));
                end
                stall = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                    stall = 0;
            end
            if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_byte_budget_lru_cache_with_pins_core: done, errors");
            $finish;
        end
    end

    function automatic req_word_t mk(input action_t a, input logic [31:0] g,
                                     input logic [15:0] p, input logic [15:0] l,
                                     input logic [31:0] b, input logic [31:0] h);
        req_word_t w;
        w.action = a;
        w.generation = g;
        w.page = p;
        w.range_last = l;
        w.image_bytes = b;
        w.image_handle = h;
        return w;
    endfunction

    task automatic wait_drain();
        while (pending_words.size() > 0 || expected_rsp.size() > 0 || req_ch.valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_budget(input logic [39:0] v);
        wait_drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        budget = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rnd_gen();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return $urandom();
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    function automatic logic [15:0] rnd_page();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 23));
    endfunction

    function automatic req_word_t rnd_word(input logic [31:0] scale);
        action_t a;
        logic [15:0] p;
        logic [31:0] b;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) a = ACT_INSERT;
        else if (pick < 58) a = ACT_LOOKUP;
        else if (pick < 64) a = ACT_PIN_CLEAR;
        else if (pick < 74) a = ACT_PIN_ADD;
        else if (pick < 77) a = ACT_CLEAR_GEN;
        else if (pick < 87) a = ACT_HOLD_ADD;
        else if (pick < 93) a = ACT_RETAIN;
        else a = ACT_ENFORCE;
        p = rnd_page();
        if ($urandom_range(0, 19) == 0)
            b = $urandom();
        else
            b = $urandom_range(0, scale);
        return mk(a, rnd_gen(), p, 16'(p + $urandom_range(0, 8) - 2), b, $urandom());
    endfunction

    initial
    begin
        logic [39:0] budgets [6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_INSERT;
        req_ch.generation = '0;
        req_ch.page = '0;
        req_ch.range_last = '0;
        req_ch.image_bytes = '0;
        req_ch.image_handle = '0;
        rsp_ch.ready = 1'b0;
        errors = 0;
        sent_words = 0;
        cycles = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            c_valid[i] = 0;
            c_pinned[i] = 0;
            c_rank[i] = 0;
        end
        for (int i = 0; i < PIN_SLOTS; i++)
            pin_ok[i] = 0;
        for (int i = 0; i < HOLD_SLOTS; i++)
            hold_ok[i] = 0;
        used = '0;
        resident = 0;
        peak = 0;
        budget = BUDGET_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        queue_word(mk(ACT_LOOKUP, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0));
        queue_word(mk(ACT_INSERT, 32'd0, 16'd0, 16'd0, 32'd100, 32'hA));
        queue_word(mk(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'd0,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_word(mk(ACT_ENFORCE, 0, 0, 0, 0, 0));
        queue_word(mk(ACT_INSERT, 32'd1, 16'd5, 0, 32'd10, 32'h55));
        queue_word(mk(ACT_INSERT, 32'd1, 16'd5, 0, 32'd20, 32'h66));
        queue_word(mk(ACT_LOOKUP, 32'd1, 16'd5, 0, 0, 0));
        queue_word(mk(ACT_PIN_ADD, 32'd1, 16'd5, 0, 0, 0));
        queue_word(mk(ACT_PIN_CLEAR, 32'd1, 0, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            queue_word(mk(ACT_HOLD_ADD, 0, 16'(i), 0, 0, 0));
        queue_word(mk(ACT_RETAIN, 32'd1, 16'd9, 16'd3, 0, 0));
        queue_word(mk(ACT_CLEAR_GEN, 32'd0, 0, 0, 0, 0));
        set_budget(40'd0);
        for (int i = 0; i < 17; i++)
            queue_word(mk(ACT_PIN_ADD, 32'd7, 16'(i), 0, 0, 0));
        for (int i = 0; i < 18; i++)
            queue_word(mk(ACT_INSERT, 32'd7, 16'(i), 0, 32'd50, $urandom()));
        queue_word(mk(ACT_ENFORCE, 0, 0, 0, 0, 0));
        queue_word(mk(ACT_CLEAR_GEN, 32'd7, 0, 0, 0, 0));
        set_budget(40'hFF_FFFF_FFFF);
        // fill table past capacity
        for (int i = 0; i < 66; i++)
            queue_word(mk(ACT_INSERT, 32'd9, 16'(i), 0, $urandom(), $urandom()));
        queue_word(mk(ACT_LOOKUP, 32'd9, 16'd3, 0, 0, 0));
        queue_word(mk(ACT_CLEAR_GEN, 32'd9, 0, 0, 0, 0));

        budgets = '{40'd2000, 40'd0, 40'hFF_FFFF_FFFF, 40'd600, 40'h1_0000_0000, 40'd5000};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_budget(budgets[ph]);
            for (int n = 0; n < 210; n++)
                queue_word(rnd_word(ph == 4 ? 32'hFFFF_FFFF : 32'd400));
        end
        wait_drain();
        if (expected_rsp.size() != 0)
            report("expected results left over");
        if (errors == 0)
            $display("tb_byte_budget_lru_cache_with_pins_core: done, clean");
        else
            $display("tb_byte_budget_lru_cache_with_pins_core: done, errors");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/bblc_pkg.sv
hw/rtl/bblc_if.sv
hw/rtl/bblc_ram.sv
hw/rtl/bblc_ctrl.sv
hw/rtl/bblc_dp.sv
hw/rtl/byte_budget_lru_cache_with_pins_core.sv
hw/rtl/bblc_chk.sv
tb/tb_byte_budget_lru_cache_with_pins_core.sv
